// File: rtl/core/ubxfh_pkg.sv
package ubxfh_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_CLASS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ID      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [7:0]  RST_MATCH_CLASS   = 8'd5;
  localparam logic [7:0]  RST_MATCH_ID      = 8'd1;
  localparam logic [15:0] RST_PAYLOAD_LIMIT = 16'd64;

  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  typedef struct packed {
    logic [7:0]  match_class;
    logic [7:0]  match_id;
    logic [15:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_position;
    logic [15:0] frame_length;
    logic        truncated;
  } result_t;

  typedef enum logic [8:0] {
    ST_HUNT    = 9'b000000001,
    ST_SYNC2   = 9'b000000010,
    ST_CLASS   = 9'b000000100,
    ST_IDENT   = 9'b000001000,
    ST_LEN_LO  = 9'b000010000,
    ST_LEN_HI  = 9'b000100000,
    ST_PAYLOAD = 9'b001000000,
    ST_CK_A    = 9'b010000000,
    ST_CK_B    = 9'b100000000
  } state_t;

endpackage

// File: rtl/core/ubxfh_byte_if.sv
interface ubxfh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/ubxfh_result_if.sv
interface ubxfh_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_position;
  logic [15:0] frame_length;
  logic        truncated;

  modport source (
    output valid, output result_kind, output payload_byte, output byte_position,
    output frame_length, output truncated, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input byte_position,
    input frame_length, input truncated, output ready
  );
endinterface

// File: rtl/core/ubx_frame_hunter.sv
// Frame hunter: takes one received byte per beat on rx and one result per beat on res.
// A byte is taken every cycle that rx is ready; the rate is set by the single hunt state
// register, which the byte updates in the cycle it is accepted. Results pass through
// a two-entry output buffer, so rx stays ready while one result waits on res; rx.ready
// drops only while two results are held. Configuration writes go through cfg_we, cfg_index
// and cfg_data (index 0 match class, 1 match id, 2 payload limit; other indexes are ignored).
module ubx_frame_hunter (
  input  logic                                clk,
  input  logic                                rst,
  ubxfh_byte_if.sink                          rx,
  ubxfh_result_if.source                      res,
  input  logic                                cfg_we,
  input  logic [ubxfh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ubxfh_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ubxfh_pkg::*;

  cfg_t    cfg;
  logic    push;
  result_t push_data;
  logic    space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_class   <= RST_MATCH_CLASS;
      cfg.match_id      <= RST_MATCH_ID;
      cfg.payload_limit <= RST_PAYLOAD_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_CLASS:   cfg.match_class   <= cfg_data[7:0];
        REG_MATCH_ID:      cfg.match_id      <= cfg_data[7:0];
        REG_PAYLOAD_LIMIT: cfg.payload_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ubxfh_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .space     (space),
    .push      (push),
    .push_data (push_data)
  );

  ubxfh_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .res       (res)
  );

endmodule

// File: rtl/core/ubxfh_parser.sv
module ubxfh_parser (
  input  logic             clk,
  input  logic             rst,
  ubxfh_byte_if.sink       rx,
  input  ubxfh_pkg::cfg_t  cfg,
  input  logic             space,
  output logic             push,
  output ubxfh_pkg::result_t push_data
);
  import ubxfh_pkg::*;

  state_t      state, state_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_ident, frame_ident_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] payload_index, payload_index_next;

  logic        accept;
  logic        frame_hit;
  logic        emit;
  logic [7:0]  c;
  logic [15:0] index_inc;
  logic [15:0] length_full;

  assign rx.ready    = space;
  assign accept      = rx.valid && rx.ready;
  assign c           = rx.rx_byte;
  assign frame_hit   = (frame_class == cfg.match_class) && (frame_ident == cfg.match_id);
  assign index_inc   = payload_index + 16'd1;
  assign length_full = {c, payload_length[7:0]};

  always_comb begin
    state_next          = state;
    frame_class_next    = frame_class;
    frame_ident_next    = frame_ident;
    payload_length_next = payload_length;
    payload_index_next  = payload_index;
    emit                = 1'b0;
    push_data           = '0;
    unique case (state)
      ST_SYNC2: begin
        state_next = (c == SYNC_SECOND) ? ST_CLASS : ST_HUNT;
      end
      ST_CLASS: begin
        frame_class_next = c;
        state_next       = ST_IDENT;
      end
      ST_IDENT: begin
        frame_ident_next = c;
        state_next       = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        payload_length_next = {8'd0, c};
        state_next          = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        payload_length_next = length_full;
        payload_index_next  = '0;
        state_next          = (length_full == 16'd0) ? ST_CK_A : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        emit                    = frame_hit && (payload_index < cfg.payload_limit);
        push_data.result_kind   = KIND_PAYLOAD;
        push_data.payload_byte  = c;
        push_data.byte_position = payload_index;
        push_data.frame_length  = payload_length;
        payload_index_next      = index_inc;
        if (index_inc >= payload_length) begin
          state_next = ST_CK_A;
        end
      end
      ST_CK_A: begin
        state_next = ST_CK_B;
      end
      ST_CK_B: begin
        emit                   = frame_hit;
        push_data.result_kind  = KIND_COMPLETE;
        push_data.frame_length = payload_length;
        push_data.truncated    = payload_length > cfg.payload_limit;
        state_next             = ST_HUNT;
      end
      default: begin
        state_next = (c == SYNC_FIRST) ? ST_SYNC2 : ST_HUNT;
      end
    endcase
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      frame_class    <= '0;
      frame_ident    <= '0;
      payload_length <= '0;
      payload_index  <= '0;
    end else if (accept) begin
      state          <= state_next;
      frame_class    <= frame_class_next;
      frame_ident    <= frame_ident_next;
      payload_length <= payload_length_next;
      payload_index  <= payload_index_next;
    end
  end

  a_push_state: assert property (@(posedge clk) disable iff (rst)
    push |-> (state == ST_PAYLOAD || state == ST_CK_B))
    else $error("result pushed outside payload or checksum state");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_CK_B) |=> state == ST_HUNT)
    else $error("frame end did not return to hunting");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state) && $stable(payload_index))
    else $error("parser state moved without a beat");

endmodule

// File: rtl/core/ubxfh_out_buf.sv
module ubxfh_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ubxfh_pkg::result_t push_data,
  output logic               space,
  ubxfh_result_if.source     res
);
  import ubxfh_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take  = res.ready || !out_valid;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid         = out_valid;
  assign res.result_kind   = out_data.result_kind;
  assign res.payload_byte  = out_data.payload_byte;
  assign res.byte_position = out_data.byte_position;
  assign res.frame_length  = out_data.frame_length;
  assign res.truncated     = out_data.truncated;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("push into full buffer");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready && push) |=> skid_valid && out_valid)
    else $error("stalled push was lost");

endmodule
